// ----- hdl/integer_to_base_digits_defines.svh -----
// Assertion macros shared by the integer-to-base-digits design
`ifndef INTEGER_TO_BASE_DIGITS_DEFINES_SVH
`define INTEGER_TO_BASE_DIGITS_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define ITBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ITBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/itbd_pkg.sv -----
// Shared types and constants for the integer-to-base-digits block
package itbd_pkg;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    typedef struct packed {
        logic               done;
        logic [RADIX_W-1:0] remainder;
    } div_status_t;

endpackage

// ----- hdl/itbd_divider.sv -----
// Bit-serial restoring divider: magnitude by a small radix, one quotient bit per cycle
module itbd_divider #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [VALUE_WIDTH-1:0]         dividend,
    input  logic [itbd_pkg::RADIX_W-1:0]   divisor,
    output logic [VALUE_WIDTH-1:0]         quotient,
    output itbd_pkg::div_status_t          status
);
    import itbd_pkg::*;
    `include "integer_to_base_digits_defines.svh"

    localparam int STEP_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [RADIX_W:0]       trial;
    logic                   fits;
    logic [RADIX_W:0]       diff;

    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign fits  = (trial >= {1'b0, divisor});
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(VALUE_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_reg <= fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
        end
    end

    assign quotient         = quo_reg;
    assign status.done      = done_reg;
    assign status.remainder = rem_reg;

    `ITBD_ASSERT_NOW(a_no_restart, clk, rst_n, start, !busy_reg,
        "divider restarted while busy")
    `ITBD_ASSERT_NOW(a_rem_range, clk, rst_n, done_reg, rem_reg < divisor,
        "remainder not below divisor")

endmodule

// ----- hdl/itbd_stack.sv -----
// Digit stack memory: one write port, one registered read port
module itbd_stack #(
    parameter int DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(DEPTH)-1:0]       waddr,
    input  logic [itbd_pkg::DIGIT_W-1:0]   wdata,
    input  logic                           re,
    input  logic [$clog2(DEPTH)-1:0]       raddr,
    output logic [itbd_pkg::DIGIT_W-1:0]   rdata
);
    import itbd_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/integer_to_base_digits.sv -----
// Top level: signed integer to digits in a configurable base, most significant first
//
//  channel   direction  handshake                  beat contents
//  -------   ---------  -------------------------  ----------------------
//  input     in         start && !busy             value
//  result    out        digit_valid (1 cycle)      digit, last_digit
//  config    in         radix_we                   radix_wdata
//
// An item keeps busy high through a LOAD/WAIT divider pass for each digit, then through
// the EMIT state; a new start is not accepted until busy falls.
// Digits leave one per cycle, each in the cycle after its stack read.
// Reset clears the sequencer and sets radix to 10; the digit stack is not cleared.
// The receiver cannot stall; every beat is taken in the cycle it is shown.
module integer_to_base_digits #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [VALUE_WIDTH-1:0]        value,
    input  logic                                 radix_we,
    input  logic [itbd_pkg::RADIX_W-1:0]         radix_wdata,
    output logic                                 digit_valid,
    output logic signed [itbd_pkg::DIGIT_W-1:0]  digit,
    output logic                                 last_digit
);
    import itbd_pkg::*;
    `include "integer_to_base_digits_defines.svh"

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t                 state_reg,     state_next;
    logic [VALUE_WIDTH-1:0] quot_reg,      quot_next;
    logic                   neg_reg,       neg_next;
    logic [RADIX_W-1:0]     rdx_reg,       rdx_next;
    logic [CNT_W-1:0]       count_reg,     count_next;
    logic [IDX_W-1:0]       rd_idx_reg,    rd_idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_last_reg,  out_last_next;
    logic [RADIX_W-1:0]     radix_reg;

    logic                   accept;
    logic [VALUE_WIDTH-1:0] value_u;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [RADIX_W-1:0]     radix_eff;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_quotient;
    div_status_t            div_status;

    logic                   push;
    logic [DIGIT_W-1:0]     push_digit;
    logic                   rd_en;
    logic [DIGIT_W-1:0]     rd_data;

    assign accept    = start && (state_reg == ST_IDLE);
    assign value_u   = value;
    assign magnitude = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
    assign radix_eff = (radix_reg < RADIX_MIN) ? RADIX_MIN :
                       (radix_reg > RADIX_MAX) ? RADIX_MAX : radix_reg;

    assign div_start  = (state_reg == ST_LOAD);
    assign push       = (state_reg == ST_WAIT) && div_status.done;
    assign push_digit = neg_reg ? (~{1'b0, div_status.remainder} + 1'b1)
                                : {1'b0, div_status.remainder};
    assign rd_en      = (state_reg == ST_EMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (radix_we)
        begin
            radix_reg <= radix_wdata;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        neg_next       = neg_reg;
        rdx_next       = rdx_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    quot_next  = magnitude;
                    neg_next   = value_u[VALUE_WIDTH-1];
                    rdx_next   = radix_eff;
                    count_next = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_status.done)
                begin
                    quot_next  = div_quotient;
                    count_next = count_reg + 1'b1;
                    if ((div_quotient == '0) || (count_reg == CNT_W'(MAX_DIGITS - 1)))
                    begin
                        rd_idx_next = count_reg[IDX_W-1:0];
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                out_last_next  = (rd_idx_reg == '0);
                if (rd_idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quot_reg      <= '0;
            neg_reg       <= 1'b0;
            rdx_reg       <= RADIX_RESET;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quot_reg      <= quot_next;
            neg_reg       <= neg_next;
            rdx_reg       <= rdx_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    itbd_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (quot_reg),
        .divisor  (rdx_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    itbd_stack #(
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .clk   (clk),
        .we    (push),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (push_digit),
        .re    (rd_en),
        .raddr (rd_idx_reg),
        .rdata (rd_data)
    );

    assign busy        = (state_reg != ST_IDLE);
    assign digit_valid = out_valid_reg;
    assign digit       = rd_data;
    assign last_digit  = out_last_reg;

    `ITBD_ASSERT_NEXT(a_run_ends, clk, rst_n, out_valid_reg && out_last_reg, !out_valid_reg,
        "beat shown after the final digit")
    `ITBD_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_DIGITS),
        "digit count past stack depth")
    `ITBD_ASSERT_NEXT(a_accept_loads, clk, rst_n, accept, state_reg == ST_LOAD && count_reg == '0,
        "accepted item did not start a division")

endmodule

// ----- dv/tb_integer_to_base_digits.sv -----
// Self-checking testbench for integer_to_base_digits: directed and random radix conversions
`timescale 1ns / 1ps

module tb_integer_to_base_digits;

    import itbd_pkg::*;

    localparam int VW         = 32;
    localparam int MAX_DIGITS = 32;

    typedef struct packed {
        logic signed [DIGIT_W-1:0] digit;
        logic                      last;
    } digit_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [VW-1:0]       value = '0;
    logic                       radix_we = 1'b0;
    logic [RADIX_W-1:0]         radix_wdata = '0;
    logic                       digit_valid;
    logic signed [DIGIT_W-1:0]  digit;
    logic                       last_digit;

    digit_beat_t        digits_due[$];
    logic [RADIX_W-1:0] radix_now = RADIX_RESET;
    int                 mismatch_count = 0;
    bit                 steady = 1'b0;

    integer_to_base_digits #(
        .VALUE_WIDTH(VW),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .radix_we   (radix_we),
        .radix_wdata(radix_wdata),
        .digit_valid(digit_valid),
        .digit      (digit),
        .last_digit (last_digit)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("integer_to_base_digits test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void predict_digits(input logic signed [VW-1:0] v);
        logic [VW-1:0]             mag;
        logic [VW-1:0]             base;
        logic [VW-1:0]             rem;
        logic [RADIX_W-1:0]        r6;
        logic                      neg;
        logic signed [DIGIT_W-1:0] stack[MAX_DIGITS];
        int                        n;
        digit_beat_t               beat;
        neg = v[VW-1];
        mag = neg ? (~v + 1'b1) : v;
        r6 = radix_now;
        if (r6 < RADIX_MIN)
            r6 = RADIX_MIN;
        else if (r6 > RADIX_MAX)
            r6 = RADIX_MAX;
        base = VW'(r6);
        n = 0;
        do
        begin
            rem = mag % base;
            if (n < MAX_DIGITS)
            begin
                stack[n] = neg ? -rem[DIGIT_W-1:0] : rem[DIGIT_W-1:0];
                n++;
            end
            mag = mag / base;
        end
        while (mag != 0);
        for (int k = n - 1; k >= 0; k--)
        begin
            beat.digit = stack[k];
            beat.last  = (k == 0);
            digits_due.push_back(beat);
        end
    endfunction

    // check result beats first, then record an accepted input or a radix write
    always @(posedge clk)
    begin
        digit_beat_t exp_beat;
        if (rst_n)
        begin
            if (digit_valid)
            begin
                if (digits_due.size() == 0)
                    report_mismatch($sformatf("unexpected digit %0d last %0b",
                                              digit, last_digit));
                else
                begin
                    exp_beat = digits_due.pop_front();
                    if (digit !== exp_beat.digit)
                        report_mismatch($sformatf("digit %0d, expected %0d",
                                                  digit, exp_beat.digit));
                    if (last_digit !== exp_beat.last)
                        report_mismatch($sformatf("last_digit %0b, expected %0b",
                                                  last_digit, exp_beat.last));
                end
            end
            if (start && !busy)
                predict_digits(value);
            if (radix_we)
                radix_now = radix_wdata;
        end
    end

    task automatic sender_pause();
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_value(input logic signed [VW-1:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        sender_pause();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (digits_due.size() != 0 || busy)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_drained();
        radix_we    <= 1'b1;
        radix_wdata <= r;
        @(posedge clk);
        radix_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [VW-1:0] pick_value();
        logic signed [VW-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 1000);
            2: v = -$signed(VW'($urandom_range(0, 1000)));
            3:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            4: v = $signed(VW'($urandom_range(0, 2000))) - 1000;
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic test_reset_radix();
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(10);
        send_value(-10);
        send_value(32'sh7fff_ffff);
        send_value(32'sh8000_0000);
    endtask

    task automatic test_radix_extremes();
        write_radix(RADIX_MIN);
        send_value(32'sh8000_0000);
        send_value(32'sh7fff_ffff);
        send_value(0);
        write_radix(RADIX_MAX);
        send_value(35);
        send_value(-35);
        send_value(36);
        send_value(32'sh8000_0000);
    endtask

    task automatic test_radix_clamp();
        write_radix(6'd0);
        send_value(5);
        write_radix(6'd1);
        send_value(-3);
        write_radix(6'd37);
        send_value(71);
        write_radix(6'd63);
        send_value(-1295);
        send_value(32'sh8000_0000);
    endtask

    task automatic test_random_radix_sweep();
        logic [RADIX_W-1:0] r;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: r = RADIX_MIN;
                1: r = RADIX_MAX;
                4: r = 6'd16;
                5: r = 6'd0;
                6: r = 6'd63;
                default: r = RADIX_W'($urandom_range(0, 63));
            endcase
            write_radix(r);
            repeat (40) send_value(pick_value());
        end
    endtask

    task automatic test_steady_stream();
        write_radix(RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX)));
        steady = 1'b1;
        repeat (40) send_value(pick_value());
    endtask

    initial
    begin
        int guard;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_radix();
        test_radix_extremes();
        test_radix_clamp();
        test_random_radix_sweep();
        test_steady_stream();
        start <= 1'b0;
        @(posedge clk);
        guard = 0;
        while ((digits_due.size() != 0 || busy) && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
        if (digits_due.size() != 0)
            report_mismatch($sformatf("%0d digits never arrived", digits_due.size()));
        if (mismatch_count == 0)
            $display("integer_to_base_digits test passed");
        else
            $display("integer_to_base_digits test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/itbd_pkg.sv
hdl/itbd_divider.sv
hdl/itbd_stack.sv
hdl/integer_to_base_digits.sv
dv/tb_integer_to_base_digits.sv
